/* sv/grid_tie_connect_sequencer_assert.svh */
// ----------------------------------------------------------------------------
// grid tie connect sequencer assertion macros
// concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef GRID_TIE_CONNECT_SEQUENCER_ASSERT_SVH
`define GRID_TIE_CONNECT_SEQUENCER_ASSERT_SVH
`ifndef SYNTHESIS
`define GTCS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("gtcs assertion failed");
`define GTCS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  `GTCS_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))
`define GTCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  `GTCS_ASSERT(lbl, clk, rst_n, (ante) |=> (cons))
`else
`define GTCS_ASSERT(lbl, clk, rst_n, prop)
`define GTCS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define GTCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* sv/gtcs_pkg.sv */
// ----------------------------------------------------------------------------
// gtcs_pkg
// types, register indexes and constants of the grid tie connect sequencer
// ----------------------------------------------------------------------------
package gtcs_pkg;

  // pi in Q3.13
  localparam logic [15:0] PI_Q13 = 16'd25736;

  localparam logic [15:0] RELAY_DELAY_RST  = 16'd600;
  localparam logic [15:0] RAMP_PERIOD_RST  = 16'd200;
  localparam logic [14:0] RAMP_STEP_RST    = 15'd128;
  localparam logic [14:0] REF_LIMIT_RST    = 15'd2560;
  localparam logic [15:0] PHASE_WINDOW_RST = 16'd819;
  localparam logic [14:0] CUR_THRESH_RST   = 15'd38;
  localparam logic [14:0] AMP_RST          = 15'd128;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_RELAY_DELAY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_PERIOD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REF_LIMIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_WINDOW = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CUR_THRESH   = 3'd5;

  localparam logic [2:0] MODE_CODE_INITIAL = 3'd0;
  localparam logic [2:0] MODE_CODE_RELAY   = 3'd1;
  localparam logic [2:0] MODE_CODE_PWM     = 3'd2;
  localparam logic [2:0] MODE_CODE_CURRENT = 3'd3;
  localparam logic [2:0] MODE_CODE_FAULT   = 3'd4;

  typedef enum logic [4:0] {
    M_INITIAL = 5'b00001,
    M_RELAY   = 5'b00010,
    M_PWM     = 5'b00100,
    M_CURRENT = 5'b01000,
    M_FAULT   = 5'b10000
  } mode_t;

  typedef struct packed {
    logic [15:0] relay_delay;
    logic [15:0] ramp_period;
    logic [14:0] ramp_step;
    logic [14:0] ref_limit;
    logic [15:0] phase_window;
    logic [14:0] cur_thresh;
  } gtcs_cfg_t;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] relay_cnt;
    logic [15:0] ramp_cnt;
    logic        ramp_armed;
    logic [14:0] amplitude;
    logic        pwm_on;
    logic        relays_on;
  } gtcs_state_t;

  function automatic logic [2:0] mode_code(input mode_t m);
    logic [2:0] code;
    case (m)
      M_INITIAL: code = MODE_CODE_INITIAL;
      M_RELAY:   code = MODE_CODE_RELAY;
      M_PWM:     code = MODE_CODE_PWM;
      M_CURRENT: code = MODE_CODE_CURRENT;
      M_FAULT:   code = MODE_CODE_FAULT;
      default:   code = MODE_CODE_INITIAL;
    endcase
    return code;
  endfunction

endpackage

/* sv/gtcs_step.sv */
// ----------------------------------------------------------------------------
// gtcs_step
// next-state logic of the sequencer for one control tick
// ----------------------------------------------------------------------------
module gtcs_step (
  input  gtcs_pkg::gtcs_cfg_t   cfg,
  input  gtcs_pkg::gtcs_state_t cur,
  input  logic [15:0]           phase,
  input  logic signed [15:0]    grid_current,
  input  logic                  error_detected,
  input  logic                  key_enable,
  input  logic                  key_disable,
  output gtcs_pkg::gtcs_state_t nxt
);
  import gtcs_pkg::*;

  logic        near_zero;
  logic        near_pi;
  logic        cur_big;
  logic [15:0] dpi;
  logic [15:0] mag;

  assign near_zero = phase < cfg.phase_window;
  assign dpi       = (phase >= PI_Q13) ? (phase - PI_Q13) : (PI_Q13 - phase);
  assign near_pi   = dpi < cfg.phase_window;
  // magnitude of -32768 is 32768, still fits unsigned 16 bits
  assign mag       = grid_current[15] ? (~grid_current + 16'd1) : grid_current;
  assign cur_big   = mag > {1'b0, cfg.cur_thresh};

  always_comb begin
    gtcs_state_t s;
    logic [15:0] sum;
    s   = cur;
    sum = '0;

    if (error_detected || s.mode == M_FAULT) begin
      s.mode      = M_FAULT;
      s.pwm_on    = 1'b0;
      s.relays_on = 1'b0;
    end

    // reference ramp
    if (s.mode == M_CURRENT) begin
      s.ramp_armed = s.ramp_armed | near_zero;
      if (s.ramp_armed) begin
        s.ramp_cnt = s.ramp_cnt + 16'd1;
      end
      if (s.ramp_cnt >= cfg.ramp_period) begin
        s.ramp_cnt  = '0;
        sum         = {1'b0, s.amplitude} + {1'b0, cfg.ramp_step};
        s.amplitude = (sum >= {1'b0, cfg.ref_limit}) ? cfg.ref_limit : sum[14:0];
      end
    end

    if (key_enable && s.mode != M_FAULT) begin
      s.relays_on = 1'b1;
      if (near_zero) begin
        s.mode      = M_RELAY;
        s.relay_cnt = '0;
      end
    end

    if (s.mode == M_RELAY) begin
      s.relay_cnt = s.relay_cnt + 16'd1;
      if (s.relay_cnt >= cfg.relay_delay) begin
        s.mode      = M_PWM;
        s.relay_cnt = '0;
      end
    end

    if (key_disable) begin
      s.mode      = M_FAULT;
      s.pwm_on    = 1'b0;
      s.relays_on = 1'b0;
    end

    if (s.mode == M_PWM) begin
      s.pwm_on = 1'b1;
      if (near_zero || near_pi || cur_big) begin
        s.mode = M_CURRENT;
      end
    end

    nxt = s;
  end

endmodule

/* sv/grid_tie_connect_sequencer.sv */
// ----------------------------------------------------------------------------
// grid_tie_connect_sequencer
// steps a grid-tie inverter from relay close through PWM enable into current
// control, ramps the current reference and latches faults
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall   | phase, grid_current, error, keys
//  out_    | output    | out_valid/out_stall | mode, amplitude, pwm, relays
//  cfg_    | input     | cfg_wr_en           | cfg_index, cfg_wdata
//
// one transaction per cycle sustained while out_stall is low; a result is loaded
// into the result register when its input leaves the input register, and the next
// item sees the sequencer state that this same advance updates
// reset returns the control state to M_INITIAL with the default amplitude and loads the register defaults
// a stalled result holds; the input register still takes one more
// transaction, and in_stall rises only when both registers are full
module grid_tie_connect_sequencer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [15:0]                         in_phase,
  input  logic signed [15:0]                  in_grid_current,
  input  logic                                in_error_detected,
  input  logic                                in_key_enable,
  input  logic                                in_key_disable,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [2:0]                          out_mode,
  output logic [14:0]                         out_reference_amplitude,
  output logic                                out_pwm_enabled,
  output logic                                out_relays_closed,
  input  logic                                cfg_wr_en,
  input  logic [gtcs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gtcs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import gtcs_pkg::*;

`include "grid_tie_connect_sequencer_assert.svh"

  gtcs_cfg_t   cfg_r;
  gtcs_state_t state_r;
  gtcs_state_t state_nxt;

  logic               s1_valid_r;
  logic [15:0]        s1_phase_r;
  logic signed [15:0] s1_current_r;
  logic               s1_err_r;
  logic               s1_ken_r;
  logic               s1_kdis_r;

  logic        out_valid_r;
  logic [2:0]  out_mode_r;
  logic [14:0] out_amp_r;
  logic        out_pwm_r;
  logic        out_relays_r;

  logic in_accept;
  logic advance;

  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.relay_delay  <= RELAY_DELAY_RST;
      cfg_r.ramp_period  <= RAMP_PERIOD_RST;
      cfg_r.ramp_step    <= RAMP_STEP_RST;
      cfg_r.ref_limit    <= REF_LIMIT_RST;
      cfg_r.phase_window <= PHASE_WINDOW_RST;
      cfg_r.cur_thresh   <= CUR_THRESH_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_RELAY_DELAY:  cfg_r.relay_delay  <= cfg_wdata;
        REG_RAMP_PERIOD:  cfg_r.ramp_period  <= cfg_wdata;
        REG_RAMP_STEP:    cfg_r.ramp_step    <= cfg_wdata[14:0];
        REG_REF_LIMIT:    cfg_r.ref_limit    <= cfg_wdata[14:0];
        REG_PHASE_WINDOW: cfg_r.phase_window <= cfg_wdata;
        REG_CUR_THRESH:   cfg_r.cur_thresh   <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_phase_r   <= in_phase;
      s1_current_r <= in_grid_current;
      s1_err_r     <= in_error_detected;
      s1_ken_r     <= in_key_enable;
      s1_kdis_r    <= in_key_disable;
    end
  end

  gtcs_step u_step (
    .cfg            (cfg_r),
    .cur            (state_r),
    .phase          (s1_phase_r),
    .grid_current   (s1_current_r),
    .error_detected (s1_err_r),
    .key_enable     (s1_ken_r),
    .key_disable    (s1_kdis_r),
    .nxt            (state_nxt)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode       <= M_INITIAL;
      state_r.relay_cnt  <= '0;
      state_r.ramp_cnt   <= '0;
      state_r.ramp_armed <= 1'b0;
      state_r.amplitude  <= AMP_RST;
      state_r.pwm_on     <= 1'b0;
      state_r.relays_on  <= 1'b0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_mode_r   <= mode_code(state_nxt.mode);
      out_amp_r    <= state_nxt.amplitude;
      out_pwm_r    <= state_nxt.pwm_on;
      out_relays_r <= state_nxt.relays_on;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_mode                = out_mode_r;
  assign out_reference_amplitude = out_amp_r;
  assign out_pwm_enabled         = out_pwm_r;
  assign out_relays_closed       = out_relays_r;

  `GTCS_ASSERT_IMPL(a_fault_outputs_off, clk, rst_n,
                    out_valid_r && out_mode_r == MODE_CODE_FAULT,
                    !out_pwm_r && !out_relays_r)
  `GTCS_ASSERT_NEXT(a_fault_absorbing, clk, rst_n,
                    state_r.mode == M_FAULT, state_r.mode == M_FAULT)
  `GTCS_ASSERT(a_pwm_needs_relays, clk, rst_n, !state_r.pwm_on || state_r.relays_on)
  `GTCS_ASSERT_NEXT(a_item_held_on_stall, clk, rst_n,
                    s1_valid_r && out_valid_r && out_stall,
                    s1_valid_r && $stable(state_r))

endmodule
